// ----- rtl/core/chfm_pkg.sv -----
// Shared types, constants, arctangent table and control store for the compass heading unit.
package chfm_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int HEADING_FRAC_DEF = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN = 3'd3;

  localparam logic [7:0]  ADJUST_RESET = 8'd128;
  localparam logic [15:0] GAIN_RESET   = 16'd4096;

  // datapath widths
  localparam int UV_W   = 35;   // CORDIC vector components, signed
  localparam int Z_W    = 24;   // CORDIC angle accumulator, signed Q16 degrees
  localparam int ATAN_W = 22;   // one arctangent table entry
  localparam int H_W    = 25;   // heading in Q16 degrees, 0 to 360
  localparam int P1_W   = 26;   // magnitude times adjustment factor
  localparam int P2_W   = 42;   // times common gain

  localparam logic [H_W-1:0] DEG90_Q16  = 25'(90 << 16);
  localparam logic [H_W-1:0] DEG180_Q16 = 25'(180 << 16);
  localparam logic [H_W-1:0] DEG270_Q16 = 25'(270 << 16);

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic               sensor_overflow;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic [14:0]        heading_deg;
    logic               sample_dropped;
    logic               saturated;
  } out_beat_t;

  // control store
  localparam int PC_W = 4;

  localparam logic [3:0] OP_IDLE   = 4'd0;
  localparam logic [3:0] OP_NOP    = 4'd1;
  localparam logic [3:0] OP_MUL1   = 4'd2;
  localparam logic [3:0] OP_MUL2   = 4'd3;
  localparam logic [3:0] OP_SAT    = 4'd4;
  localparam logic [3:0] OP_SETUP  = 4'd5;
  localparam logic [3:0] OP_ITER   = 4'd6;
  localparam logic [3:0] OP_ANGLE  = 4'd7;
  localparam logic [3:0] OP_FINISH = 4'd8;

  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_NOACC     = 3'd2;
  localparam logic [2:0] C_DROP      = 3'd3;
  localparam logic [2:0] C_AXIS_MORE = 3'd4;
  localparam logic [2:0] C_YZERO     = 3'd5;
  localparam logic [2:0] C_ITER_MORE = 3'd6;
  localparam logic [2:0] C_OUT_BUSY  = 3'd7;

  localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ST_CHECK  = 4'd1;
  localparam logic [PC_W-1:0] ST_MUL1   = 4'd2;
  localparam logic [PC_W-1:0] ST_MUL2   = 4'd3;
  localparam logic [PC_W-1:0] ST_SAT    = 4'd4;
  localparam logic [PC_W-1:0] ST_SETUP  = 4'd5;
  localparam logic [PC_W-1:0] ST_ITER   = 4'd6;
  localparam logic [PC_W-1:0] ST_ANGLE  = 4'd7;
  localparam logic [PC_W-1:0] ST_FINISH = 4'd8;
  localparam logic [PC_W-1:0] ST_RETURN = 4'd9;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // one control word per step: jump to target when cond holds, else advance
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      ST_IDLE:   w = '{op: OP_IDLE,   cond: C_NOACC,     target: ST_IDLE};
      ST_CHECK:  w = '{op: OP_NOP,    cond: C_DROP,      target: ST_SETUP};
      ST_MUL1:   w = '{op: OP_MUL1,   cond: C_NEVER,     target: ST_IDLE};
      ST_MUL2:   w = '{op: OP_MUL2,   cond: C_NEVER,     target: ST_IDLE};
      ST_SAT:    w = '{op: OP_SAT,    cond: C_AXIS_MORE, target: ST_MUL1};
      ST_SETUP:  w = '{op: OP_SETUP,  cond: C_YZERO,     target: ST_FINISH};
      ST_ITER:   w = '{op: OP_ITER,   cond: C_ITER_MORE, target: ST_ITER};
      ST_ANGLE:  w = '{op: OP_ANGLE,  cond: C_NEVER,     target: ST_IDLE};
      ST_FINISH: w = '{op: OP_FINISH, cond: C_OUT_BUSY,  target: ST_FINISH};
      ST_RETURN: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_IDLE};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      5'd0:    a = 22'd2949120;
      5'd1:    a = 22'd1740967;
      5'd2:    a = 22'd919879;
      5'd3:    a = 22'd466945;
      5'd4:    a = 22'd234379;
      5'd5:    a = 22'd117304;
      5'd6:    a = 22'd58666;
      5'd7:    a = 22'd29335;
      5'd8:    a = 22'd14668;
      5'd9:    a = 22'd7334;
      5'd10:   a = 22'd3667;
      5'd11:   a = 22'd1833;
      5'd12:   a = 22'd917;
      5'd13:   a = 22'd458;
      5'd14:   a = 22'd229;
      5'd15:   a = 22'd115;
      5'd16:   a = 22'd57;
      5'd17:   a = 22'd29;
      5'd18:   a = 22'd14;
      5'd19:   a = 22'd7;
      5'd20:   a = 22'd4;
      5'd21:   a = 22'd2;
      5'd22:   a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  // magnitude of a signed 16-bit value, exact for the most negative code
  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

endpackage

// ----- rtl/core/compass_heading_from_magnetometer_unit.sv -----
// Compass heading unit: per-axis scaling of magnetometer samples and a microcoded CORDIC heading.
//
// One sample beat in, one result beat out. Each axis magnitude is multiplied by its sensitivity
// factor (adjust+128)/256 and the Q4.12 common gain, truncated toward zero and saturated to
// 16 bits; an overflowed sample leaves the stored axes untouched. The heading is worked out from
// the stored x and y with a vectoring CORDIC and reported in 2^-HEADING_FRAC_BITS degree units,
// 0 to 360; with both stored x and y zero the previous heading is kept. A ten-step control store
// sequences one shared datapath, and one sample occupies it from accept to release, through three
// multiply/saturate steps per axis and one CORDIC iteration per cycle. A dropped sample skips the
// axis scaling, and a stored y of zero skips the CORDIC. The result sits in an output register,
// so the next sample is taken while it waits; the sequencer only holds when it finishes a new
// result while the previous one is still stalled. Configuration writes are always ready and are
// meant for idle periods.
module compass_heading_from_magnetometer_unit #(
  parameter int CORDIC_STEPS      = chfm_pkg::CORDIC_STEPS_DEF,
  parameter int HEADING_FRAC_BITS = chfm_pkg::HEADING_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  chfm_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output chfm_pkg::out_beat_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import chfm_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);
  // rounding shift from Q16 degrees down to the output fraction
  localparam int SH = 16 - HEADING_FRAC_BITS;
  localparam logic [17:0] HEAD_TOP = 18'(360 << HEADING_FRAC_BITS);
  localparam logic [17:0] CODE_MAX = 18'd32767;
  localparam logic [H_W:0] ROUND_HALF = (H_W + 1)'(1) << (SH - 1);

  // sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            jump;
  logic            accept;
  logic            out_busy;

  // configuration
  logic [7:0]  adj_x_r, adj_y_r, adj_z_r;
  logic [7:0]  adj_x_nxt, adj_y_nxt, adj_z_nxt;
  logic [15:0] gain_r, gain_nxt;

  // sample and scaling datapath
  in_beat_t         in_q_r, in_q_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic             clip_r, clip_nxt;
  logic             neg_r, neg_nxt;
  logic [P1_W-1:0]  prod1_r, prod1_nxt;
  logic [P2_W-1:0]  prod2_r, prod2_nxt;
  logic signed [15:0] held_x_r, held_y_r, held_z_r;
  logic signed [15:0] held_x_nxt, held_y_nxt, held_z_nxt;
  logic [14:0]      held_heading_r, held_heading_nxt;

  logic signed [15:0] raw_sel;
  logic [7:0]       adj_sel;
  logic [16:0]      mag;
  logic [8:0]       adj_factor;
  logic [21:0]      q;
  logic [21:0]      q_neg;
  logic signed [15:0] axis_val;
  logic             axis_clip;

  // CORDIC datapath
  logic signed [UV_W-1:0] u_r, u_nxt, v_r, v_nxt;
  logic signed [UV_W-1:0] u_sh, v_sh;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic signed [Z_W-1:0]  atan_step;
  logic [IW-1:0]          iter_r, iter_nxt;
  logic [16:0]            abs_x, abs_y;
  logic [H_W-1:0]         h_r, h_nxt;
  logic [22:0]            z_clamp;
  logic [H_W-1:0]         h_base;
  logic                   keep_r, keep_nxt;
  logic [H_W:0]           round_sum;
  logic [17:0]            code;
  logic [14:0]            heading_new;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;

  assign uw        = ucode_rom(pc_r);
  assign in_stall  = (uw.op != OP_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // axis operand select
  always_comb begin
    case (axis_r)
      2'd0: begin
        raw_sel = in_q_r.raw_x;
        adj_sel = adj_x_r;
      end
      2'd1: begin
        raw_sel = in_q_r.raw_y;
        adj_sel = adj_y_r;
      end
      default: begin
        raw_sel = in_q_r.raw_z;
        adj_sel = adj_z_r;
      end
    endcase
  end

  assign mag        = abs16(raw_sel);
  assign adj_factor = {1'b0, adj_sel} + 9'd128;

  // saturate the scaled magnitude back to a signed axis value
  assign q     = prod2_r[P2_W-1:20];
  assign q_neg = -q;
  always_comb begin
    if (neg_r) begin
      axis_clip = (q > 22'd32768);
      axis_val  = axis_clip ? 16'sh8000 : $signed(q_neg[15:0]);
    end else begin
      axis_clip = (q > 22'd32767);
      axis_val  = axis_clip ? 16'sh7FFF : $signed(q[15:0]);
    end
  end

  assign abs_x     = abs16(held_x_r);
  assign abs_y     = abs16(held_y_r);
  assign u_sh      = u_r >>> iter_r;
  assign v_sh      = v_r >>> iter_r;
  assign atan_step = $signed({2'b00, atan_q16(5'(iter_r))});

  // clamp the CORDIC angle to 0..90 degrees and fold in the quadrant
  always_comb begin
    if (z_r < 0) begin
      z_clamp = 23'd0;
    end else if (z_r > $signed({1'b0, DEG90_Q16[22:0]})) begin
      z_clamp = DEG90_Q16[22:0];
    end else begin
      z_clamp = z_r[22:0];
    end
  end
  assign h_base = held_y_r[15] ? DEG270_Q16 : DEG90_Q16;

  // round half up to the output fraction, then clamp
  assign round_sum = {1'b0, h_r} + ROUND_HALF;
  always_comb begin
    code = 18'(round_sum >> SH);
    if (code > HEAD_TOP) begin
      code = HEAD_TOP;
    end
    if (code > CODE_MAX) begin
      code = CODE_MAX;
    end
  end
  assign heading_new = keep_r ? held_heading_r : code[14:0];

  // next step
  always_comb begin
    case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NOACC:     jump = !accept;
      C_DROP:      jump = in_q_r.sensor_overflow;
      C_AXIS_MORE: jump = (axis_r != 2'd2);
      C_YZERO:     jump = (held_y_r == 16'sd0);
      C_ITER_MORE: jump = (iter_r != IW'(CORDIC_STEPS - 1));
      C_OUT_BUSY:  jump = out_busy;
      default:     jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.target : pc_r + 1'b1;
  end

  // datapath driven by the current control word
  always_comb begin
    in_q_nxt         = in_q_r;
    axis_nxt         = axis_r;
    clip_nxt         = clip_r;
    neg_nxt          = neg_r;
    prod1_nxt        = prod1_r;
    prod2_nxt        = prod2_r;
    held_x_nxt       = held_x_r;
    held_y_nxt       = held_y_r;
    held_z_nxt       = held_z_r;
    held_heading_nxt = held_heading_r;
    u_nxt            = u_r;
    v_nxt            = v_r;
    z_nxt            = z_r;
    iter_nxt         = iter_r;
    h_nxt            = h_r;
    keep_nxt         = keep_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    case (uw.op)
      OP_IDLE: begin
        if (accept) begin
          in_q_nxt = in_data;
          axis_nxt = 2'd0;
          clip_nxt = 1'b0;
        end
      end
      OP_MUL1: begin
        neg_nxt   = raw_sel[15];
        prod1_nxt = P1_W'(mag) * P1_W'(adj_factor);
      end
      OP_MUL2: begin
        prod2_nxt = P2_W'(prod1_r) * P2_W'(gain_r);
      end
      OP_SAT: begin
        clip_nxt = clip_r | axis_clip;
        axis_nxt = axis_r + 2'd1;
        case (axis_r)
          2'd0:    held_x_nxt = axis_val;
          2'd1:    held_y_nxt = axis_val;
          default: held_z_nxt = axis_val;
        endcase
      end
      OP_SETUP: begin
        // vector starts at (|y|, |x|) scaled by 2^16
        u_nxt    = $signed(UV_W'({abs_y, 16'h0000}));
        v_nxt    = $signed(UV_W'({abs_x, 16'h0000}));
        z_nxt    = '0;
        iter_nxt = '0;
        keep_nxt = (held_y_r == 16'sd0) && (held_x_r == 16'sd0);
        h_nxt    = held_x_r[15] ? DEG180_Q16 : '0;
      end
      OP_ITER: begin
        if (!v_r[UV_W-1]) begin
          u_nxt = u_r + v_sh;
          v_nxt = v_r - u_sh;
          z_nxt = z_r + atan_step;
        end else begin
          u_nxt = u_r - v_sh;
          v_nxt = v_r + u_sh;
          z_nxt = z_r - atan_step;
        end
        iter_nxt = iter_r + 1'b1;
      end
      OP_ANGLE: begin
        // opposite signs mirror the angle about the base direction
        if (held_x_r[15] != held_y_r[15]) begin
          h_nxt = h_base + H_W'(z_clamp);
        end else begin
          h_nxt = h_base - H_W'(z_clamp);
        end
      end
      OP_FINISH: begin
        if (!out_busy) begin
          held_heading_nxt            = heading_new;
          out_valid_nxt               = 1'b1;
          out_data_nxt.field_x        = held_x_r;
          out_data_nxt.field_y        = held_y_r;
          out_data_nxt.field_z        = held_z_r;
          out_data_nxt.heading_deg    = heading_new;
          out_data_nxt.sample_dropped = in_q_r.sensor_overflow;
          out_data_nxt.saturated      = clip_r;
        end
      end
      default: begin
      end
    endcase
  end

  // register writes
  always_comb begin
    adj_x_nxt = adj_x_r;
    adj_y_nxt = adj_y_r;
    adj_z_nxt = adj_z_r;
    gain_nxt  = gain_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADJUST_X:   adj_x_nxt = cfg_data[7:0];
        REG_ADJUST_Y:   adj_y_nxt = cfg_data[7:0];
        REG_ADJUST_Z:   adj_z_nxt = cfg_data[7:0];
        REG_SCALE_GAIN: gain_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= ST_IDLE;
      out_valid_r    <= 1'b0;
      adj_x_r        <= ADJUST_RESET;
      adj_y_r        <= ADJUST_RESET;
      adj_z_r        <= ADJUST_RESET;
      gain_r         <= GAIN_RESET;
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_z_r       <= '0;
      held_heading_r <= '0;
    end else begin
      pc_r           <= pc_nxt;
      out_valid_r    <= out_valid_nxt;
      adj_x_r        <= adj_x_nxt;
      adj_y_r        <= adj_y_nxt;
      adj_z_r        <= adj_z_nxt;
      gain_r         <= gain_nxt;
      held_x_r       <= held_x_nxt;
      held_y_r       <= held_y_nxt;
      held_z_r       <= held_z_nxt;
      held_heading_r <= held_heading_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    in_q_r     <= in_q_nxt;
    axis_r     <= axis_nxt;
    clip_r     <= clip_nxt;
    neg_r      <= neg_nxt;
    prod1_r    <= prod1_nxt;
    prod2_r    <= prod2_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    z_r        <= z_nxt;
    iter_r     <= iter_nxt;
    h_r        <= h_nxt;
    keep_r     <= keep_nxt;
    out_data_r <= out_data_nxt;
  end

  // a result appears only out of the finishing step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(uw.op == OP_FINISH))
    else $error("result valid rose outside the finishing step");

  // an accepted sample always starts at the drop check
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pc_r == ST_CHECK))
    else $error("sequencer did not advance after accept");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (18'(out_data_r.heading_deg) <= HEAD_TOP))
    else $error("heading beyond 360 degrees");

  a_drop_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.sample_dropped) |-> !out_data_r.saturated)
    else $error("dropped sample reported clipping");

endmodule

// ----- verif/tb_compass_heading_from_magnetometer_unit.sv -----
// Self-checking testbench for the compass heading unit: scaling, saturation, drop and heading.
module tb_compass_heading_from_magnetometer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import chfm_pkg::*;

  // Run-wide knobs.
  localparam int WATCHDOG_LIMIT  = 3000;  // quiet cycles before declaring a hang
  localparam int SETTLE_CYCLES   = 48;
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall for the pressure test
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 165;

  // Heading arithmetic of the default build.
  localparam int CORDIC_N    = CORDIC_STEPS_DEF;
  localparam int ROUND_SHIFT = 16 - HEADING_FRAC_DEF;
  localparam longint FULL_TURN_CODE = longint'(360) << HEADING_FRAC_DEF;

  // Any index past the last mapped register must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED = REG_SCALE_GAIN + 1'b1;
  localparam logic [CFG_IDX_W-1:0] LAST_UNMAPPED  = '1;

  // atan(2^-i) in Q16 degrees, rounded to nearest.
  localparam longint ARCTAN_STEP_Q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_beat_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_beat_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow copy of the block's registers and stored axes.
  logic [7:0]         adj_x_q, adj_y_q, adj_z_q;
  logic [15:0]        gain_q;
  logic signed [15:0] stored_x, stored_y, stored_z;
  logic [14:0]        stored_heading;

  out_beat_t predicted_readouts[$];
  int        mismatch_count;
  int        quiet_cycles;
  int        burst_left;
  bit        hold_off_req;

  compass_heading_from_magnetometer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Multiply one raw axis by (adj+128)/256 and the Q4.12 gain, truncating toward
  // zero on the magnitude, then clip to 16 bits.
  function automatic logic signed [15:0] scale_reading(input logic signed [15:0] raw,
                                                       input logic [7:0] adj,
                                                       input logic [15:0] gain,
                                                       output bit clipped);
    longint unsigned mag;
    longint unsigned prod;
    mag  = (raw < 0) ? longint'(-longint'(raw)) : longint'(raw);
    prod = (mag * (longint'(adj) + 128) * longint'(gain)) >> 20;
    clipped = 1'b0;
    if (raw < 0) begin
      if (prod > 32768) begin
        clipped = 1'b1;
        return 16'sh8000;
      end
      return 16'(-longint'(prod));
    end
    if (prod > 32767) begin
      clipped = 1'b1;
      return 16'sh7fff;
    end
    return 16'(prod);
  endfunction

  // Vectoring CORDIC on (a, b), a and b non-negative: returns atan(b/a) in Q16
  // degrees, clamped to the first quadrant.
  function automatic longint arctan_q16(input longint a, input longint b);
    longint u, v, z, du, dv;
    int     i;
    u = a <<< 16;
    v = b <<< 16;
    z = 0;
    for (i = 0; i < CORDIC_N && i < 24; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u += du;
        v -= dv;
        z += ARCTAN_STEP_Q16[i];
      end else begin
        u -= du;
        v += dv;
        z -= ARCTAN_STEP_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) <<< 16)) z = longint'(90) <<< 16;
    return z;
  endfunction

  // Advance the shadow state by one sample beat and return the readout it causes.
  function automatic out_beat_t predict_readout(input in_beat_t s);
    out_beat_t r;
    bit        clip_x, clip_y, clip_z;
    longint    h, t, ax, ay, code;
    bit        keep;
    clip_x = 1'b0;
    clip_y = 1'b0;
    clip_z = 1'b0;
    if (!s.sensor_overflow) begin
      stored_x = scale_reading(s.raw_x, adj_x_q, gain_q, clip_x);
      stored_y = scale_reading(s.raw_y, adj_y_q, gain_q, clip_y);
      stored_z = scale_reading(s.raw_z, adj_z_q, gain_q, clip_z);
    end
    keep = 1'b0;
    h    = 0;
    if (stored_y == 0) begin
      // On the x axis: due south when x is negative, north when positive.
      if (stored_x < 0) h = longint'(180) <<< 16;
      else if (stored_x > 0) h = 0;
      else keep = 1'b1;
    end else begin
      ax = (stored_x < 0) ? -longint'(stored_x) : longint'(stored_x);
      ay = (stored_y < 0) ? -longint'(stored_y) : longint'(stored_y);
      t  = arctan_q16(ay, ax);
      if ((stored_x < 0) != (stored_y < 0)) t = -t;
      h = ((stored_y > 0) ? (longint'(90) <<< 16) : (longint'(270) <<< 16)) - t;
    end
    if (!keep) begin
      code = (h + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (code > FULL_TURN_CODE) code = FULL_TURN_CODE;
      if (code > 32767) code = 32767;
      stored_heading = 15'(code);
    end
    r.field_x        = stored_x;
    r.field_y        = stored_y;
    r.field_z        = stored_z;
    r.heading_deg    = stored_heading;
    r.sample_dropped = s.sensor_overflow;
    r.saturated      = clip_x | clip_y | clip_z;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ADJUST_X:   adj_x_q = val[7:0];
      REG_ADJUST_Y:   adj_y_q = val[7:0];
      REG_ADJUST_Z:   adj_z_q = val[7:0];
      REG_SCALE_GAIN: gain_q  = val;
      default: ;  // unmapped index: the block drops the write
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one sample beat from the falling edge and hold it until accepted; the
  // prediction is taken at the accepting edge so the register shadow is current.
  task automatic send_sample(input in_beat_t s);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    predicted_readouts.push_back(predict_readout(s));
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Drop valid, drain every expected readout, then let the sequencer go idle.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [7:0] ax, input logic [7:0] ay,
                                input logic [7:0] az, input logic [15:0] g);
    write_reg(REG_ADJUST_X, {8'd0, ax});
    write_reg(REG_ADJUST_Y, {8'd0, ay});
    write_reg(REG_ADJUST_Z, {8'd0, az});
    write_reg(REG_SCALE_GAIN, g);
  endtask

  function automatic in_beat_t make_sample(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z,
                                           input logic ovf);
    in_beat_t s;
    s.raw_x           = x;
    s.raw_y           = y;
    s.raw_z           = z;
    s.sensor_overflow = ovf;
    return s;
  endfunction

  // Mix of full-range, small, extreme and zero readings; zeros put the
  // vector on an axis or at the origin.
  function automatic logic signed [15:0] pick_reading();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom);
      5, 6:          return 16'(int'($urandom_range(0, 600)) - 300);
      7: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh8001;
          default: return 16'sh7ffe;
        endcase
      end
      8:       return 16'sd0;
      default: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
    endcase
  endfunction

  function automatic logic [7:0] pick_adjust();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return ADJUST_RESET;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return GAIN_RESET;
      3:       return 16'($urandom_range(1, 8192));
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall patterns, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    stall_mode_e mode;
    int          seg_left;
    int          tick;
    mode     = STALL_NONE;
    seg_left = 0;
    tick     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        tick++;
        case (mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          default:      out_stall <= tick[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted readout against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input out_beat_t want, input out_beat_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: readout mismatch (%s)", $realtime, what);
      $display("  expected x=%0d y=%0d z=%0d heading=%0d dropped=%0b sat=%0b",
               want.field_x, want.field_y, want.field_z, want.heading_deg,
               want.sample_dropped, want.saturated);
      $display("  actual   x=%0d y=%0d z=%0d heading=%0d dropped=%0b sat=%0b",
               got.field_x, got.field_y, got.field_z, got.heading_deg,
               got.sample_dropped, got.saturated);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_readouts.size() == 0) begin
        note_mismatch("no readout expected", '0, out_data);
      end else begin
        want = predicted_readouts.pop_front();
        bad  = "";
        if (out_data.field_x !== want.field_x)               bad = {bad, " field_x"};
        if (out_data.field_y !== want.field_y)               bad = {bad, " field_y"};
        if (out_data.field_z !== want.field_z)               bad = {bad, " field_z"};
        if (out_data.heading_deg !== want.heading_deg)       bad = {bad, " heading_deg"};
        if (out_data.sample_dropped !== want.sample_dropped) bad = {bad, " sample_dropped"};
        if (out_data.saturated !== want.saturated)           bad = {bad, " saturated"};
        if (bad != "") note_mismatch({"wrong", bad}, want, out_data);
      end
    end
  end

  // Hang detector: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d readouts outstanding",
               quiet_cycles, predicted_readouts.size());
      $display("** compass_heading_from_magnetometer_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset gains (factor one): compass points, axis cases, origin hold and drops.
  task automatic test_compass_points();
    send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 1'b0));          // origin: heading holds 0
    send_sample(make_sample(16'sh7fff, 16'sd0, 16'sd0, 1'b0));       // north
    send_sample(make_sample(16'sh8000, 16'sd0, 16'sh8000, 1'b0));    // south
    send_sample(make_sample(16'sd0, 16'sh7fff, 16'sh7fff, 1'b0));    // east
    send_sample(make_sample(16'sd0, 16'sh8000, -16'sd1, 1'b0));      // west
    pace_sender();
    send_sample(make_sample(16'sd1000, 16'sd1000, 16'sd7, 1'b0));
    send_sample(make_sample(-16'sd1000, -16'sd1000, 16'sd0, 1'b0));
    send_sample(make_sample(16'sd5, -16'sd3, 16'sd1, 1'b0));
    // overflowed beat: keep stored axes, recompute heading from them
    send_sample(make_sample(16'sh7fff, 16'sh8000, 16'sh5555, 1'b1));
    send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 1'b0));          // origin keeps last heading
    send_sample(make_sample(-16'sd1, -16'sd1, -16'sd1, 1'b1));
    drain_block();
  endtask

  // Register extremes: full gain saturates, zero gain collapses to the origin.
  task automatic test_register_extremes();
    write_all_regs(8'd255, 8'd255, 8'd255, 16'hffff);
    send_sample(make_sample(16'sh7fff, 16'sh8000, 16'sd1, 1'b0));
    send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));          // drop never saturates
    send_sample(make_sample(16'sd1, -16'sd1, 16'sd2, 1'b0));
    drain_block();
    write_all_regs(8'd0, 8'd0, 8'd0, 16'd0);
    send_sample(make_sample(16'sh8000, 16'sh7fff, -16'sd1, 1'b0));
    send_sample(make_sample(16'sh2aaa, 16'sh5555, 16'sh1234, 1'b1));
    drain_block();
    write_reg(REG_SCALE_GAIN, 16'hffff);
    write_reg(FIRST_UNMAPPED, 16'hffff);                             // must be ignored
    write_reg(LAST_UNMAPPED, 16'h0000);
    send_sample(make_sample(16'sh8000, 16'sh7fff, -16'sd1, 1'b0));
    drain_block();
    write_all_regs(ADJUST_RESET, ADJUST_RESET, ADJUST_RESET, GAIN_RESET);
  endtask

  // Hold the result side for a long stretch while the sender keeps offering,
  // so the output register fills and the input stalls.
  task automatic test_hold_off_pressure();
    hold_off_req = 1'b1;
    repeat (12) begin
      send_sample(make_sample(pick_reading(), pick_reading(), pick_reading(),
                              $urandom_range(0, 7) == 0));
    end
    drain_block();
  endtask

  // Random register settings per phase after the first, which uses the reset values; random beats in bursts.
  task automatic test_random_phases();
    logic signed [15:0] x, y;
    int                 phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        write_all_regs(ADJUST_RESET, ADJUST_RESET, ADJUST_RESET, GAIN_RESET);
      end else begin
        write_all_regs(pick_adjust(), pick_adjust(), pick_adjust(), pick_gain());
        if ($urandom_range(0, 2) == 0) begin
          write_reg(CFG_IDX_W'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED)), 16'($urandom));
        end
      end
      repeat (BEATS_PER_PHASE) begin
        pace_sender();
        x = pick_reading();
        y = pick_reading();
        if ($urandom_range(0, 15) == 0) y = x;        // exact diagonal
        send_sample(make_sample(x, y, pick_reading(), $urandom_range(0, 9) == 0));
      end
      drain_block();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    adj_x_q = ADJUST_RESET;
    adj_y_q = ADJUST_RESET;
    adj_z_q = ADJUST_RESET;
    gain_q  = GAIN_RESET;
    stored_x = '0;
    stored_y = '0;
    stored_z = '0;
    stored_heading = '0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);

    test_compass_points();
    test_register_extremes();
    test_hold_off_pressure();
    test_random_phases();
    drain_block();

    if (mismatch_count == 0) begin
      $display("** compass_heading_from_magnetometer_unit: PASSED **");
    end else begin
      $display("%0d readout mismatches", mismatch_count);
      $display("** compass_heading_from_magnetometer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- compass_heading_from_magnetometer_unit.f -----
rtl/core/chfm_pkg.sv
rtl/core/compass_heading_from_magnetometer_unit.sv
verif/tb_compass_heading_from_magnetometer_unit.sv
